[rtl/core/cdk_pkg.sv]
// ----------------------------------------------------------------------------
// cdk_pkg
// Shared types, microcode encodings and calendar helper functions for the
// calendar date keeper.
// ----------------------------------------------------------------------------
package cdk_pkg;

  localparam int PC_W = 4;

  // operation codes on the input channel
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ADV_DAY  = 2'd1;
  localparam logic [1:0] OP_SET_DATE = 2'd2;
  localparam logic [1:0] OP_FACTORY  = 2'd3;

  localparam logic [7:0]  DEFAULT_YEAR = 8'd6;
  localparam logic [15:0] BASE_YEAR    = 16'd2000;
  localparam logic [7:0]  HOURS_PER_DAY = 8'd24;
  localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LATCH,
    UOP_LOAD_HW,
    UOP_ADD_DAY,
    UOP_LOAD_DATE,
    UOP_DEFAULTS,
    UOP_ROLL,
    UOP_WDAY,
    UOP_FIX,
    UOP_EMIT
  } uop_t;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_HOUR_LT_DAY,
    JMP_YEAR_LOW,
    JMP_OUT_BUSY
  } jmp_t;

  typedef struct packed {
    uop_t            uop;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       hour_lt_day;
    logic       year_low;
    logic       out_busy;
  } status_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_TICK      = 4'd1;
  localparam logic [PC_W-1:0] PC_ADV       = 4'd2;
  localparam logic [PC_W-1:0] PC_NCHK      = 4'd3;
  localparam logic [PC_W-1:0] PC_ROLL      = 4'd4;
  localparam logic [PC_W-1:0] PC_ROLL_WDAY = 4'd5;
  localparam logic [PC_W-1:0] PC_FIX       = 4'd6;
  localparam logic [PC_W-1:0] PC_SET       = 4'd7;
  localparam logic [PC_W-1:0] PC_SET_LOAD  = 4'd8;
  localparam logic [PC_W-1:0] PC_SET_WDAY  = 4'd9;
  localparam logic [PC_W-1:0] PC_FACTORY   = 4'd10;
  localparam logic [PC_W-1:0] PC_WAIT      = 4'd11;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd12;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{uop: UOP_NOP, jmp: JMP_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE:      c = '{uop: UOP_LATCH,     jmp: JMP_DISPATCH,    target: PC_IDLE};
      PC_TICK:      c = '{uop: UOP_LOAD_HW,   jmp: JMP_ALWAYS,      target: PC_NCHK};
      PC_ADV:       c = '{uop: UOP_ADD_DAY,   jmp: JMP_NONE,        target: PC_IDLE};
      PC_NCHK:      c = '{uop: UOP_NOP,       jmp: JMP_HOUR_LT_DAY, target: PC_FIX};
      PC_ROLL:      c = '{uop: UOP_ROLL,      jmp: JMP_NONE,        target: PC_IDLE};
      PC_ROLL_WDAY: c = '{uop: UOP_WDAY,      jmp: JMP_ALWAYS,      target: PC_NCHK};
      PC_FIX:       c = '{uop: UOP_FIX,       jmp: JMP_ALWAYS,      target: PC_WAIT};
      PC_SET:       c = '{uop: UOP_NOP,       jmp: JMP_YEAR_LOW,    target: PC_WAIT};
      PC_SET_LOAD:  c = '{uop: UOP_LOAD_DATE, jmp: JMP_NONE,        target: PC_IDLE};
      PC_SET_WDAY:  c = '{uop: UOP_WDAY,      jmp: JMP_ALWAYS,      target: PC_WAIT};
      PC_FACTORY:   c = '{uop: UOP_DEFAULTS,  jmp: JMP_NONE,        target: PC_IDLE};
      PC_WAIT:      c = '{uop: UOP_NOP,       jmp: JMP_OUT_BUSY,    target: PC_WAIT};
      PC_EMIT:      c = '{uop: UOP_EMIT,      jmp: JMP_ALWAYS,      target: PC_IDLE};
      default:      c = '{uop: UOP_NOP,       jmp: JMP_ALWAYS,      target: PC_IDLE};
    endcase
    return c;
  endfunction

  function automatic logic [PC_W-1:0] op_entry(input logic [1:0] op);
    logic [PC_W-1:0] e;
    case (op)
      OP_TICK:     e = PC_TICK;
      OP_ADV_DAY:  e = PC_ADV;
      OP_SET_DATE: e = PC_SET;
      OP_FACTORY:  e = PC_FACTORY;
      default:     e = PC_IDLE;
    endcase
    return e;
  endfunction

  // invalid months map to january
  function automatic logic [3:0] month_idx(input logic [3:0] m);
    logic [3:0] i;
    if (m < 4'd1 || m > 4'd12) begin
      i = 4'd0;
    end else begin
      i = m - 4'd1;
    end
    return i;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] i);
    logic [4:0] n;
    case (i)
      4'd1:                   n = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] month_code(input logic [3:0] i);
    logic [2:0] c;
    case (i)
      4'd0:    c = 3'd0;
      4'd1:    c = 3'd3;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd6;
      4'd4:    c = 3'd1;
      4'd5:    c = 3'd4;
      4'd6:    c = 3'd6;
      4'd7:    c = 3'd2;
      4'd8:    c = 3'd5;
      4'd9:    c = 3'd0;
      4'd10:   c = 3'd3;
      4'd11:   c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [7:0] y, input logic [3:0] m);
    logic [4:0] n;
    n = month_len(month_idx(m));
    if (m == 4'd2 && y[1:0] == 2'b00) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

  function automatic logic [2:0] weekday_of(input logic [7:0] y, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [3:0] mi;
    logic [8:0] s;
    logic [4:0] a;
    logic [3:0] b;
    mi = month_idx(m);
    s = 9'd6 + {1'b0, y} + {3'b0, y[7:2]} + {6'b0, month_code(mi)} + {4'b0, d};
    if (y[1:0] == 2'b00 && mi < 4'd2) begin
      s = s - 9'd1;
    end
    // 8 = 1 mod 7, so octal digits fold
    a = {2'b0, s[8:6]} + {2'b0, s[5:3]} + {2'b0, s[2:0]};
    b = {2'b0, a[4:3]} + {1'b0, a[2:0]};
    if (b >= 4'd7) begin
      b = b - 4'd7;
    end
    return b[2:0];
  endfunction

endpackage

[rtl/core/calendar_date_keeper.sv]
// ----------------------------------------------------------------------------
// calendar_date_keeper
// Calendar keeper: year offset, month, day, hour, minute and weekday,
// updated by tick, advance-day, set-date and factory-reset operations.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with op and its operands. in_stall is
// low only out of reset while the sequencer sits at its idle step, so one
// operation is worked on at a time. Output channel: out_valid / out_stall, one
// result per operation, held in an output register; the next operation can be
// taken while that result still waits for its transfer.
// Tick and advance day run the rollover loop once per day rolled over, at
// most 10 times on a tick; set date skips its load and weekday steps when
// the year is below 2000; factory reset loads the defaults. Every operation
// then passes the wait step and emits its result.
// The rollover loop (subtract a day, step the date, recompute weekday, test
// the hour) runs as three microcode steps per day on one shared datapath.
// A stalled output holds the sequencer at its wait step; the result is not
// overwritten. Reset puts the calendar at 2006-01-01 00:00, Sunday, clears
// the output valid and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module calendar_date_keeper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  hw_hour,
  input  logic [5:0]  hw_minute,
  input  logic [15:0] set_full_year,
  input  logic [3:0]  set_month,
  input  logic [4:0]  set_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  year_offset,
  output logic [3:0]  month_now,
  output logic [4:0]  day_now,
  output logic [7:0]  hour_now,
  output logic [5:0]  minute_now,
  output logic [2:0]  weekday,
  output logic        minute_changed,
  output logic [3:0]  days_rolled
);

  cdk_pkg::ctrl_t   ctrl;
  cdk_pkg::status_t status;

  // captured operands
  logic [1:0]  op_q;
  logic [7:0]  hw_hour_q;
  logic [5:0]  hw_minute_q;
  logic [15:0] set_full_year_q;
  logic [3:0]  set_month_q;
  logic [4:0]  set_day_q;

  // calendar state
  logic [7:0] year_reg;
  logic [3:0] month_reg;
  logic [4:0] day_reg;
  logic [7:0] hour_reg;
  logic [5:0] minute_reg;
  logic [5:0] last_minute_reg;
  logic [2:0] weekday_reg;
  logic       elapsed;
  logic [3:0] rolled;

  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [4:0]  month_days;
  logic [15:0] year_diff;

  cdk_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_stall = rst || (ctrl.uop != cdk_pkg::UOP_LATCH);

  always_comb begin
    status.in_valid    = in_valid;
    status.in_op       = op;
    status.hour_lt_day = (hour_reg < cdk_pkg::HOURS_PER_DAY);
    status.year_low    = (set_full_year_q < cdk_pkg::BASE_YEAR);
    status.out_busy    = out_valid && out_stall;
  end

  assign day_inc    = {1'b0, day_reg} + 6'd1;
  assign month_inc  = {1'b0, month_reg} + 5'd1;
  assign month_days = cdk_pkg::days_in_month(year_reg, month_reg);
  assign year_diff  = set_full_year_q - cdk_pkg::BASE_YEAR;

  always_ff @(posedge clk) begin
    if (ctrl.uop == cdk_pkg::UOP_LATCH && in_valid) begin
      op_q            <= op;
      hw_hour_q       <= hw_hour;
      hw_minute_q     <= hw_minute;
      set_full_year_q <= set_full_year;
      set_month_q     <= set_month;
      set_day_q       <= set_day;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year_reg        <= cdk_pkg::DEFAULT_YEAR;
      month_reg       <= 4'd1;
      day_reg         <= 5'd1;
      hour_reg        <= 8'd0;
      minute_reg      <= 6'd0;
      last_minute_reg <= 6'd0;
      weekday_reg     <= 3'd0;
      elapsed         <= 1'b0;
      rolled          <= 4'd0;
    end else begin
      case (ctrl.uop)
        cdk_pkg::UOP_LATCH: begin
          if (in_valid) begin
            elapsed <= 1'b0;
            rolled  <= 4'd0;
          end
        end
        cdk_pkg::UOP_LOAD_HW: begin
          hour_reg   <= hw_hour_q;
          minute_reg <= hw_minute_q;
        end
        cdk_pkg::UOP_ADD_DAY: begin
          hour_reg <= hour_reg + cdk_pkg::HOURS_PER_DAY;
        end
        cdk_pkg::UOP_LOAD_DATE: begin
          year_reg <= year_diff[7:0];
          if (set_month_q < 4'd1 || set_month_q > 4'd12) begin
            month_reg <= 4'd1;
          end else begin
            month_reg <= set_month_q;
          end
          day_reg <= (set_day_q == 5'd0) ? 5'd1 : set_day_q;
        end
        cdk_pkg::UOP_DEFAULTS: begin
          year_reg        <= cdk_pkg::DEFAULT_YEAR;
          month_reg       <= 4'd1;
          day_reg         <= 5'd1;
          hour_reg        <= 8'd0;
          minute_reg      <= 6'd0;
          last_minute_reg <= 6'd0;
          // 2006-01-01 is a sunday
          weekday_reg     <= 3'd0;
        end
        cdk_pkg::UOP_ROLL: begin
          hour_reg <= hour_reg - cdk_pkg::HOURS_PER_DAY;
          rolled   <= rolled + 4'd1;
          if (day_inc > {1'b0, month_days}) begin
            day_reg <= 5'd1;
            if (month_inc > cdk_pkg::MONTHS_PER_YEAR) begin
              month_reg <= 4'd1;
              year_reg  <= year_reg + 8'd1;
            end else begin
              month_reg <= month_inc[3:0];
            end
          end else begin
            day_reg <= day_inc[4:0];
          end
        end
        cdk_pkg::UOP_WDAY: begin
          weekday_reg <= cdk_pkg::weekday_of(year_reg, month_reg, day_reg);
        end
        cdk_pkg::UOP_FIX: begin
          if (month_reg < 4'd1 || month_reg > 4'd12) begin
            month_reg <= 4'd1;
          end
          if (day_reg == 5'd0) begin
            day_reg <= 5'd1;
          end
          // only a tick reports and records the minute
          if (op_q == cdk_pkg::OP_TICK) begin
            elapsed         <= (minute_reg != last_minute_reg);
            last_minute_reg <= minute_reg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.uop == cdk_pkg::UOP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == cdk_pkg::UOP_EMIT) begin
      year_offset    <= year_reg;
      month_now      <= month_reg;
      day_now        <= day_reg;
      hour_now       <= hour_reg;
      minute_now     <= minute_reg;
      weekday        <= weekday_reg;
      minute_changed <= elapsed;
      days_rolled    <= rolled;
    end
  end

endmodule

[rtl/core/cdk_sequencer.sv]
// ----------------------------------------------------------------------------
// cdk_sequencer
// Step counter and microcode store; emits one control word per cycle and
// branches on datapath status.
// ----------------------------------------------------------------------------
module cdk_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  cdk_pkg::status_t status,
  output cdk_pkg::ctrl_t   ctrl
);

  logic [cdk_pkg::PC_W-1:0] pc;
  logic [cdk_pkg::PC_W-1:0] pc_next;

  assign ctrl = cdk_pkg::ucode(pc);

  always_comb begin
    pc_next = pc + 4'd1;
    case (ctrl.jmp)
      cdk_pkg::JMP_NONE:        pc_next = pc + 4'd1;
      cdk_pkg::JMP_ALWAYS:      pc_next = ctrl.target;
      cdk_pkg::JMP_DISPATCH: begin
        // hold until a transfer, then go to the op's routine
        pc_next = status.in_valid ? cdk_pkg::op_entry(status.in_op) : pc;
      end
      cdk_pkg::JMP_HOUR_LT_DAY: pc_next = status.hour_lt_day ? ctrl.target : pc + 4'd1;
      cdk_pkg::JMP_YEAR_LOW:    pc_next = status.year_low ? ctrl.target : pc + 4'd1;
      cdk_pkg::JMP_OUT_BUSY:    pc_next = status.out_busy ? ctrl.target : pc + 4'd1;
      default:                  pc_next = cdk_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cdk_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[test/calendar_date_keeper_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_keeper_test
// Self-checking bench for the calendar keeper. A short table of directed
// operations (extremes, invalid set-date fields, year wrap, leap days, factory
// reset) is followed by random operation streams under three idle mixes. An
// in-bench calendar model predicts the results not fixed in the table, and a
// scoreboard checks each output transfer field by field in order.
// ----------------------------------------------------------------------------
module calendar_date_keeper_test;

  localparam int NUM_DIRECTED = 24;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int STALL_BURST = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  hw_hour;
    logic [5:0]  hw_minute;
    logic [15:0] full_year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_cmd_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [7:0] hour;
    logic [5:0] minute;
    logic [2:0] wday;
    logic       elapsed;
    logic [3:0] rolled;
  } cal_result_t;

  typedef struct packed {
    cal_cmd_t    cmd;
    logic        checked;
    cal_result_t want;
  } cal_row_t;

  localparam cal_result_t FACTORY_DATE = '{8'd6, 4'd1, 5'd1, 8'd0, 6'd0, 3'd0, 1'b0, 4'd0};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [7:0]  hw_hour;
  logic [5:0]  hw_minute;
  logic [15:0] set_full_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  year_offset;
  logic [3:0]  month_now;
  logic [4:0]  day_now;
  logic [7:0]  hour_now;
  logic [5:0]  minute_now;
  logic [2:0]  weekday;
  logic        minute_changed;
  logic [3:0]  days_rolled;

  calendar_date_keeper uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .hw_hour(hw_hour),
    .hw_minute(hw_minute),
    .set_full_year(set_full_year),
    .set_month(set_month),
    .set_day(set_day),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .year_offset(year_offset),
    .month_now(month_now),
    .day_now(day_now),
    .hour_now(hour_now),
    .minute_now(minute_now),
    .weekday(weekday),
    .minute_changed(minute_changed),
    .days_rolled(days_rolled)
  );

  // calendar state as the block should hold it
  logic [7:0] cal_year;
  logic [3:0] cal_month;
  logic [4:0] cal_day;
  logic [7:0] cal_hour;
  logic [5:0] cal_minute;
  logic [5:0] cal_last_minute;
  logic [2:0] cal_wday;

  cal_result_t pending_dates[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_burst_req = 0;
  int quiet_cycles = 0;

  cal_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{cdk_pkg::OP_FACTORY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b1, FACTORY_DATE},
    '{'{cdk_pkg::OP_TICK,     8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b1, FACTORY_DATE},
    '{'{cdk_pkg::OP_TICK,     8'd255, 6'd59, 16'd0,     4'd0,  5'd0},  1'b1,
      '{8'd6, 4'd1, 5'd11, 8'd15, 6'd59, 3'd3, 1'b1, 4'd10}},
    // year below 2000 leaves everything alone
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd0,     4'd5,  5'd5},  1'b1,
      '{8'd6, 4'd1, 5'd11, 8'd15, 6'd59, 3'd3, 1'b0, 4'd0}},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd65535, 4'd15, 5'd31}, 1'b0, '0},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2000,  4'd2,  5'd29}, 1'b0, '0},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2255,  4'd12, 5'd31}, 1'b0, '0},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2010,  4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2011,  4'd13, 5'd5},  1'b0, '0},
    // day past the end of february rolls into march
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2001,  4'd2,  5'd31}, 1'b0, '0},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2100,  4'd2,  5'd28}, 1'b0, '0},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_TICK,     8'd23,  6'd63, 16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_TICK,     8'd23,  6'd63, 16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_TICK,     8'd24,  6'd0,  16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_SET_DATE, 8'd0,   6'd0,  16'd2004,  4'd12, 5'd31}, 1'b0, '0},
    '{'{cdk_pkg::OP_TICK,     8'd48,  6'd32, 16'd0,     4'd0,  5'd0},  1'b0, '0},
    '{'{cdk_pkg::OP_FACTORY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b1, FACTORY_DATE},
    '{'{cdk_pkg::OP_TICK,     8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b1, FACTORY_DATE},
    '{'{cdk_pkg::OP_ADV_DAY,  8'd0,   6'd0,  16'd0,     4'd0,  5'd0},  1'b1,
      '{8'd6, 4'd1, 5'd2, 8'd0, 6'd0, 3'd1, 1'b0, 4'd1}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int month_length(input logic [7:0] y, input logic [3:0] m);
    int n;
    case (m)
      4'd2:                    n = (y[1:0] == 2'b00) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 30;
      default:                 n = 31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] wday_predict(input logic [7:0] y, input logic [3:0] m,
                                              input logic [4:0] d);
    int mi;
    int code;
    int s;
    mi = (m < 4'd1 || m > 4'd12) ? 0 : int'(m) - 1;
    case (mi)
      1, 2, 10: code = 3;
      3, 6:     code = 6;
      4:        code = 1;
      5:        code = 4;
      7:        code = 2;
      8, 11:    code = 5;
      default:  code = 0;
    endcase
    s = 6 + int'(y) + int'(y) / 4 + code + int'(d);
    // january and february of a leap year count one day less
    if (y[1:0] == 2'b00 && mi < 2) begin
      s = s - 1;
    end
    return 3'(s % 7);
  endfunction

  task automatic calendar_after(input cal_cmd_t cmd, output cal_result_t res);
    int rolled;
    int next_day;
    logic elapsed;
    rolled = 0;
    elapsed = 1'b0;
    case (cmd.op)
      cdk_pkg::OP_TICK: begin
        cal_hour = cmd.hw_hour;
        cal_minute = cmd.hw_minute;
      end
      cdk_pkg::OP_ADV_DAY: begin
        cal_hour = cal_hour + cdk_pkg::HOURS_PER_DAY;
      end
      cdk_pkg::OP_SET_DATE: begin
        if (cmd.full_year >= cdk_pkg::BASE_YEAR) begin
          cal_year = 8'(cmd.full_year - cdk_pkg::BASE_YEAR);
          cal_month = (cmd.month < 4'd1 || cmd.month > 4'd12) ? 4'd1 : cmd.month;
          cal_day = (cmd.day == 5'd0) ? 5'd1 : cmd.day;
          cal_wday = wday_predict(cal_year, cal_month, cal_day);
        end
      end
      default: begin
        cal_year = cdk_pkg::DEFAULT_YEAR;
        cal_month = 4'd1;
        cal_day = 5'd1;
        cal_hour = 8'd0;
        cal_minute = 6'd0;
        cal_last_minute = 6'd0;
        cal_wday = wday_predict(cal_year, cal_month, cal_day);
      end
    endcase
    if (cmd.op == cdk_pkg::OP_TICK || cmd.op == cdk_pkg::OP_ADV_DAY) begin
      while (cal_hour >= cdk_pkg::HOURS_PER_DAY) begin
        cal_hour = cal_hour - cdk_pkg::HOURS_PER_DAY;
        rolled++;
        next_day = int'(cal_day) + 1;
        if (next_day > month_length(cal_year, cal_month)) begin
          next_day = 1;
          cal_month = cal_month + 4'd1;
          if (cal_month > 4'd12) begin
            cal_month = 4'd1;
            cal_year = cal_year + 8'd1;
          end
        end
        cal_day = 5'(next_day);
        cal_wday = wday_predict(cal_year, cal_month, cal_day);
      end
      if (cal_month < 4'd1 || cal_month > 4'd12) begin
        cal_month = 4'd1;
      end
      if (cal_day == 5'd0) begin
        cal_day = 5'd1;
      end
    end
    if (cmd.op == cdk_pkg::OP_TICK) begin
      elapsed = (cal_minute != cal_last_minute);
      cal_last_minute = cal_minute;
    end
    res = '{cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_wday, elapsed, 4'(rolled)};
  endtask

  // holds the operation on the input until it transfers
  task automatic offer(input cal_cmd_t cmd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= cmd.op;
    hw_hour <= cmd.hw_hour;
    hw_minute <= cmd.hw_minute;
    set_full_year <= cmd.full_year;
    set_month <= cmd.month;
    set_day <= cmd.day;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    cal_cmd_t cmd;
    cal_result_t res;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    op = cdk_pkg::OP_TICK;
    hw_hour = 8'd0;
    hw_minute = 6'd0;
    set_full_year = 16'd0;
    set_month = 4'd0;
    set_day = 5'd0;
    cmd = '0;
    cmd.op = cdk_pkg::OP_FACTORY;
    calendar_after(cmd, res);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 47;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer(directed_rows[i].cmd);
      calendar_after(directed_rows[i].cmd, res);
      pending_dates.push_back(directed_rows[i].checked ? directed_rows[i].want : res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 30 : 0;
      // long output hold-off so the block backs up into its input
      stall_burst_req = STALL_BURST;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        cmd.hw_hour = 8'($urandom_range(255));
        cmd.hw_minute = 6'($urandom_range(63));
        cmd.full_year = 16'($urandom_range(65535));
        cmd.month = 4'($urandom_range(15));
        cmd.day = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 45) begin
          cmd.op = cdk_pkg::OP_TICK;
          if ($urandom_range(99) < 75) begin
            cmd.hw_hour = 8'($urandom_range(47));
          end
          if ($urandom_range(99) < 30) begin
            cmd.hw_minute = cal_last_minute;
          end
        end else if (pick < 70) begin
          cmd.op = cdk_pkg::OP_ADV_DAY;
        end else if (pick < 94) begin
          cmd.op = cdk_pkg::OP_SET_DATE;
          pick = $urandom_range(99);
          if (pick < 75) begin
            cmd.full_year = 16'(2000 + $urandom_range(255));
          end else if (pick < 85) begin
            cmd.full_year = 16'($urandom_range(1999));
          end
          if ($urandom_range(99) < 85) begin
            cmd.month = 4'($urandom_range(12, 1));
          end
          // month ends are where the rollovers happen
          if ($urandom_range(99) < 60) begin
            cmd.day = 5'($urandom_range(31, 25));
          end
        end else begin
          cmd.op = cdk_pkg::OP_FACTORY;
        end
        offer(cmd);
        calendar_after(cmd, res);
        pending_dates.push_back(res);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int burst_left;
    burst_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_burst_req > 0) begin
        burst_left = stall_burst_req;
        stall_burst_req = 0;
      end
      if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cal_result_t got;
    cal_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{year_offset, month_now, day_now, hour_now, minute_now, weekday,
              minute_changed, days_rolled};
      if (pending_dates.size() == 0) begin
        $display("%0t ns: result transfer expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year_offset", int'(want.year), int'(got.year));
        check_field("month_now", int'(want.month), int'(got.month));
        check_field("day_now", int'(want.day), int'(got.day));
        check_field("hour_now", int'(want.hour), int'(got.hour));
        check_field("minute_now", int'(want.minute), int'(got.minute));
        check_field("weekday", int'(want.wday), int'(got.wday));
        check_field("minute_changed", int'(want.elapsed), int'(got.elapsed));
        check_field("days_rolled", int'(want.rolled), int'(got.rolled));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
